// ===== sv/prt_pkg.sv =====
// Shared types and constants for the positional record table.
// Holds the record layout, request and status codes and the shift control bundle.
// Depends on nothing; every other file refers to it by scoped names.
package prt_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int POS_W         = 5;
    localparam int KEY_W         = 64;
    localparam int DATE_W        = 27;
    localparam int TEMP_W        = 16;
    localparam int INDEX_W       = 4;
    localparam int COUNT_W       = 5;
    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int IN_DATA_W     = 144;
    localparam int OUT_DATA_W    = 152;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_MISS   = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_third;
        logic signed [TEMP_W-1:0] temp_second;
        logic signed [TEMP_W-1:0] temp_first;
        logic        [DATE_W-1:0] date_code;
        logic        [KEY_W-1:0]  city_key;
    } record_t;

    typedef enum logic [1:0] {
        SHIFT_HOLD   = 2'd0,
        SHIFT_INSERT = 2'd1,
        SHIFT_DELETE = 2'd2,
        SHIFT_ROTATE = 2'd3
    } shift_op_t;

    typedef struct packed {
        shift_op_t        op;
        logic [POS_W-1:0] pos;
    } shift_ctrl_t;

endpackage

// ===== sv/prt_cell.sv =====
// One storage cell of the record chain: holds a single record.
// Depends on prt_pkg for the record and shift control types.
// Takes its left neighbor, its right neighbor, the new record, or holds.
module prt_cell #(
    parameter int DEPTH = prt_pkg::DEPTH_DEFAULT,
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  prt_pkg::shift_ctrl_t ctrl,
    input  prt_pkg::record_t    new_rec,
    input  prt_pkg::record_t    left_rec,
    input  prt_pkg::record_t    right_rec,
    output prt_pkg::record_t    rec
);

    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = ((IW > prt_pkg::POS_W) ? IW : prt_pkg::POS_W) + 1;

    prt_pkg::record_t rec_reg;
    prt_pkg::record_t rec_next;
    logic [CMP_W-1:0] idx_c;
    logic [CMP_W-1:0] pos_c;

    assign idx_c = CMP_W'(INDEX);
    assign pos_c = CMP_W'(ctrl.pos);

    always_comb
    begin
        rec_next = rec_reg;
        case (ctrl.op)
            prt_pkg::SHIFT_INSERT:
            begin
                if (idx_c > pos_c)
                begin
                    rec_next = left_rec;
                end
                else if (idx_c == pos_c)
                begin
                    rec_next = new_rec;
                end
            end
            prt_pkg::SHIFT_DELETE:
            begin
                if (idx_c >= pos_c)
                begin
                    rec_next = right_rec;
                end
            end
            prt_pkg::SHIFT_ROTATE:
            begin
                rec_next = right_rec;
            end
            default:
            begin
                rec_next = rec_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule

// ===== sv/positional_record_table.sv =====
// Positional record table: an ordered chain of DEPTH record cells.
// Insert, delete and any rejected request show their registered result in the next cycle.
// Search and read rotate the whole chain once past cell 0, then load the result in S_DONE.
// One request is in work at a time; a new one is taken when no result waits or in the
// cycle that it is taken; inserts and deletes can run one per cycle while m_tready is high.
// Reset (rst_n low, asynchronous) empties the table and the output; record contents
// are not cleared, and entries at or above the count are never shown.
module positional_record_table #(
    parameter int DEPTH = prt_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata, lowest bit up: position(5), city_key(64), date_code(27),
    // temp_first(16), temp_second(16), temp_third(16).
    input  logic [prt_pkg::IN_DATA_W-1:0]     s_tdata,
    // tuser: req_type(2).
    input  logic [prt_pkg::REQ_W-1:0]         s_tuser,
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata, lowest bit up: found_index(4), out_city_key(64), out_date_code(27),
    // out_temp_first(16), out_temp_second(16), out_temp_third(16),
    // entry_count(5), zero fill(4).
    output logic [prt_pkg::OUT_DATA_W-1:0]    m_tdata,
    // tuser: status(2).
    output logic [prt_pkg::STATUS_W-1:0]      m_tuser
);

    // Width of the fill count, of a cell index, and of a common compare width.
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = ((CNT_W > prt_pkg::POS_W) ? CNT_W : prt_pkg::POS_W) + 1;

    // Sequencer states. In the scan state a search or read shifts the
    // ring one place each cycle, so that cell 0 shows entry s in scan
    // step s and the table is back in order at the end.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Request fields.
    prt_pkg::req_t             req;
    logic [prt_pkg::POS_W-1:0] pos;
    prt_pkg::record_t          in_rec;
    logic                      accept;

    // Fill count.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Scan bookkeeping.
    logic [IW-1:0]             step_reg;
    logic [IW-1:0]             step_next;
    prt_pkg::req_t             scan_req_reg;
    logic [prt_pkg::POS_W-1:0] scan_pos_reg;
    logic [prt_pkg::KEY_W-1:0] scan_key_reg;
    logic                      hit_reg;
    logic                      hit_next;
    logic [IW-1:0]             hit_index_reg;
    prt_pkg::record_t          hit_rec_reg;
    logic                      take_hit;
    logic                      scan_start;

    // Output register.
    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic                        out_load;
    prt_pkg::status_t            out_status;
    logic [prt_pkg::INDEX_W-1:0] out_index;
    prt_pkg::record_t            out_rec;
    prt_pkg::status_t            m_status_reg;
    logic [prt_pkg::INDEX_W-1:0] m_index_reg;
    prt_pkg::record_t            m_rec_reg;
    logic [prt_pkg::COUNT_W-1:0] m_count_reg;

    // Cell chain.
    prt_pkg::shift_ctrl_t ctrl;
    prt_pkg::record_t     cell_rec [DEPTH];

    // Comparisons on a common width.
    logic [CW-1:0] pos_c;
    logic [CW-1:0] count_c;
    logic          full;
    logic          in_range;

    assign req                = prt_pkg::req_t'(s_tuser);
    assign pos                = s_tdata[4:0];
    assign in_rec.city_key    = s_tdata[68:5];
    assign in_rec.date_code   = s_tdata[95:69];
    assign in_rec.temp_first  = s_tdata[111:96];
    assign in_rec.temp_second = s_tdata[127:112];
    assign in_rec.temp_third  = s_tdata[143:128];

    // A request is taken in idle whenever the output slot is free or is
    // being emptied in the same cycle.
    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign pos_c    = CW'(pos);
    assign count_c  = CW'(count_reg);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign in_range = (CNT_W'(step_reg) < count_reg);

    // Request decode, shift control and result selection.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ctrl.op    = prt_pkg::SHIFT_HOLD;
        ctrl.pos   = pos;
        out_load   = 1'b0;
        out_status = prt_pkg::ST_OK;
        out_index  = '0;
        out_rec    = '0;
        scan_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req)
                        prt_pkg::REQ_INSERT:
                        begin
                            out_load = 1'b1;
                            if (pos_c > count_c)
                            begin
                                out_status = prt_pkg::ST_BADPOS;
                            end
                            else if (full)
                            begin
                                out_status = prt_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.op    = prt_pkg::SHIFT_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        prt_pkg::REQ_DELETE:
                        begin
                            out_load = 1'b1;
                            if (pos_c >= count_c)
                            begin
                                out_status = prt_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                ctrl.op    = prt_pkg::SHIFT_DELETE;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        prt_pkg::REQ_READ:
                        begin
                            if (pos_c >= count_c)
                            begin
                                out_load   = 1'b1;
                                out_status = prt_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                scan_start = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            scan_start = 1'b1;
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                ctrl.op = prt_pkg::SHIFT_ROTATE;
                if (step_reg == IW'(DEPTH - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                out_load = 1'b1;
                if (hit_reg)
                begin
                    out_index = prt_pkg::INDEX_W'(hit_index_reg);
                    out_rec   = hit_rec_reg;
                end
                else
                begin
                    out_status = prt_pkg::ST_MISS;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Cell 0 holds the entry of the current scan step. A search keeps the
    // first key match below the count; a read keeps the entry at its position.
    always_comb
    begin
        take_hit = 1'b0;
        if ((state_reg == S_SCAN) && in_range && !hit_reg)
        begin
            if (scan_req_reg == prt_pkg::REQ_READ)
            begin
                take_hit = (CW'(step_reg) == CW'(scan_pos_reg));
            end
            else
            begin
                take_hit = (cell_rec[0].city_key == scan_key_reg);
            end
        end
    end

    assign hit_next  = scan_start ? 1'b0 : (hit_reg || take_hit);
    assign step_next = (state_reg == S_SCAN) ? step_reg + IW'(1) : '0;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
    end

    // The record chain: a ring, so that a full rotation restores the order.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        localparam int LEFT  = (g == 0) ? DEPTH - 1 : g - 1;
        localparam int RIGHT = (g == DEPTH - 1) ? 0 : g + 1;

        prt_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .new_rec   (in_rec),
            .left_rec  (cell_rec[LEFT]),
            .right_rec (cell_rec[RIGHT]),
            .rec       (cell_rec[g])
        );
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            step_reg    <= '0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (scan_start)
        begin
            scan_req_reg <= req;
            scan_pos_reg <= pos;
            scan_key_reg <= in_rec.city_key;
        end
        if (take_hit)
        begin
            hit_index_reg <= step_reg;
            hit_rec_reg   <= cell_rec[0];
        end
        if (out_load)
        begin
            m_status_reg <= out_status;
            m_index_reg  <= out_index;
            m_rec_reg    <= out_rec;
            m_count_reg  <= prt_pkg::COUNT_W'(count_next);
        end
    end

    assign m_tvalid         = m_valid_reg;
    assign m_tuser          = m_status_reg;
    assign m_tdata[3:0]     = m_index_reg;
    assign m_tdata[67:4]    = m_rec_reg.city_key;
    assign m_tdata[94:68]   = m_rec_reg.date_code;
    assign m_tdata[110:95]  = m_rec_reg.temp_first;
    assign m_tdata[126:111] = m_rec_reg.temp_second;
    assign m_tdata[142:127] = m_rec_reg.temp_third;
    assign m_tdata[147:143] = m_count_reg;
    assign m_tdata[151:148] = '0;

endmodule
